@@ src/psc_pkg.sv @@
// Package for the postfix stack calculator: opcodes, error codes and the
// request and response structs between the sequencer and the arithmetic unit.
// No dependencies.
package psc_pkg;

  typedef enum logic [2:0] {
    OP_PUSH        = 3'd0,
    OP_POP         = 3'd1,
    OP_PEEK_TOP    = 3'd2,
    OP_PEEK_BOTTOM = 3'd3,
    OP_ADD         = 3'd4,
    OP_SUB         = 3'd5,
    OP_MUL         = 3'd6,
    OP_DIV         = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_FULL    = 3'd1,
    ERR_EMPTY   = 3'd2,
    ERR_RANGE   = 3'd3,
    ERR_FEW     = 3'd4,
    ERR_DIVZERO = 3'd5
  } err_e;

  localparam int unsigned DataWidth = 32;

  typedef struct packed {
    logic                 start;
    opcode_e              op;
    logic [DataWidth-1:0] lhs;
    logic [DataWidth-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic                 done;
    logic [DataWidth-1:0] result;
  } alu_rsp_t;

endpackage

@@ src/psc_in_if.sv @@
// Input channel of the postfix stack calculator: valid, ready and one command beat.
// No dependencies.
interface psc_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic signed [31:0] push_value;
  logic        [9:0]  position;

  modport source (output valid, output opcode, output push_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input push_value, input position,
                  output ready);
endinterface

@@ src/psc_out_if.sv @@
// Output channel of the postfix stack calculator: valid, ready and one result beat.
// No dependencies.
interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [2:0]  error_code;
  logic        [10:0] entry_count;

  modport source (output valid, output value, output error_code, output entry_count,
                  input ready);
  modport sink   (input valid, input value, input error_code, input entry_count,
                  output ready);
endinterface

@@ src/psc_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module psc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/psc_alu.sv @@
// Shared arithmetic unit: add, subtract and multiply with a registered result, floor
// division by a restoring shift-subtract loop, one quotient bit per cycle.
// Depends on psc_pkg.
module psc_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psc_pkg::alu_req_t  req_i,
  output psc_pkg::alu_rsp_t  rsp_o
);
  import psc_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_DIV  = 2'd1;
  localparam logic [1:0] A_FIX  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic                 done_q, done_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [DataWidth-1:0] res_q, res_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] den_q, den_d;
  logic                 flip_q, flip_d;
  logic [DataWidth:0]   rem_shift;
  logic [DataWidth:0]   diff;

  assign rem_shift = {rem_q, quo_q[DataWidth-1]};
  assign diff      = rem_shift - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    res_d   = res_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    flip_d  = flip_q;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_ADD: begin
              res_d  = req_i.lhs + req_i.rhs;
              done_d = 1'b1;
            end
            OP_SUB: begin
              res_d  = req_i.lhs - req_i.rhs;
              done_d = 1'b1;
            end
            OP_MUL: begin
              res_d  = req_i.lhs * req_i.rhs;
              done_d = 1'b1;
            end
            OP_DIV: begin
              quo_d   = req_i.lhs[DataWidth-1] ? (DataWidth'(0) - req_i.lhs) : req_i.lhs;
              den_d   = req_i.rhs[DataWidth-1] ? (DataWidth'(0) - req_i.rhs) : req_i.rhs;
              flip_d  = req_i.lhs[DataWidth-1] ^ req_i.rhs[DataWidth-1];
              rem_d   = '0;
              cnt_d   = '0;
              state_d = A_DIV;
            end
            default: begin
              res_d  = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end
      A_DIV: begin
        if (!diff[DataWidth]) begin
          rem_d = diff[DataWidth-1:0];
        end else begin
          rem_d = rem_shift[DataWidth-1:0];
        end
        quo_d = {quo_q[DataWidth-2:0], ~diff[DataWidth]};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = A_FIX;
        end
      end
      A_FIX: begin
        if (flip_q) begin
          res_d = (DataWidth'(0) - quo_q) - DataWidth'(rem_q != '0);
        end else begin
          res_d = quo_q;
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    flip_q <= flip_d;
  end

  always_comb begin
    rsp_o.done   = done_q;
    rsp_o.result = res_q;
  end

endmodule

@@ src/postfix_stack_calculator.sv @@
// Top level of the postfix stack calculator: command sequencer, stack count,
// stack RAM and the shared arithmetic unit.
// Depends on psc_pkg, psc_in_if, psc_out_if, psc_ram and psc_alu.
//
// Usage: each input beat carries an opcode, a push value and a peek position.
// Every accepted beat yields exactly one output beat with the value, an error
// code and the entry count after the operation. The stack lives in a RAM of
// DEPTH words with a registered read; its contents are undefined until pushed.
// From input beat to output beat: push and every error found before a RAM read
// end in the execute step; pop and peek add a RAM read; a divide-by-zero error
// is found once both operands are read; arithmetic then waits for the shared
// unit, whose divider produces one quotient bit per cycle. One command is in
// flight at a time; a new beat is accepted once the previous result has been
// placed in the output register, so intake overlaps a waiting result. Reset
// empties the stack at once with no clearing pass. When the receiver stalls,
// the result holds in the output register and the block finishes the next
// command up to its result, then waits until that register frees up.
module postfix_stack_calculator #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psc_in_if.sink     in_i,
  psc_out_if.source  out_o
);
  import psc_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 10) ? CW : 10;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_RIGHT = 3'd3;
  localparam logic [2:0] S_LEFT  = 3'd4;
  localparam logic [2:0] S_ALU   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state_q, state_d;
  opcode_e              op_q, op_d;
  logic [DataWidth-1:0] data_q, data_d;
  logic [9:0]           pos_q, pos_d;
  logic [CW-1:0]        count_q, count_d;
  logic [DataWidth-1:0] rhs_q, rhs_d;
  logic [DataWidth-1:0] res_value_q, res_value_d;
  err_e                 res_err_q, res_err_d;
  logic                 out_valid_q, out_valid_d;
  logic [DataWidth-1:0] out_value_q, out_value_d;
  err_e                 out_err_q, out_err_d;
  logic [10:0]          out_count_q, out_count_d;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DataWidth-1:0] wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [DataWidth-1:0] rd_data;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  logic [CW-1:0]        top_idx;
  logic [CW-1:0]        second_idx;
  logic [CW-1:0]        peek_top_idx;
  logic                 pos_bad;

  assign top_idx      = count_q - CW'(1);
  assign second_idx   = count_q - CW'(2);
  assign peek_top_idx = count_q - CW'(1) - CW'(pos_q);
  assign pos_bad      = PW'(pos_q) >= PW'(count_q);

  psc_ram #(
    .Width (DataWidth),
    .Depth (DEPTH)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  psc_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    data_d        = data_q;
    pos_d         = pos_q;
    count_d       = count_q;
    rhs_d         = rhs_q;
    res_value_d   = res_value_q;
    res_err_d     = res_err_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_value_d   = out_value_q;
    out_err_d     = out_err_q;
    out_count_d   = out_count_q;
    wr_en         = 1'b0;
    wr_addr       = AW'(count_q);
    wr_data       = data_q;
    rd_en         = 1'b0;
    rd_addr       = AW'(top_idx);
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    alu_req.lhs   = rd_data;
    alu_req.rhs   = rhs_q;
    in_i.ready    = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d    = opcode_e'(in_i.opcode);
          data_d  = in_i.push_value;
          pos_d   = in_i.position;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_value_d = '0;
        res_err_d   = ERR_OK;
        state_d     = S_DONE;
        case (op_q)
          OP_PUSH: begin
            if (count_q == CW'(DEPTH)) begin
              res_err_d = ERR_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CW'(1);
            end
          end
          OP_POP: begin
            if (count_q == '0) begin
              res_err_d = ERR_EMPTY;
            end else begin
              rd_en   = 1'b1;
              state_d = S_READ;
            end
          end
          OP_PEEK_TOP, OP_PEEK_BOTTOM: begin
            if (pos_bad) begin
              res_err_d = ERR_RANGE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = (op_q == OP_PEEK_TOP) ? AW'(peek_top_idx) : AW'(pos_q);
              state_d = S_READ;
            end
          end
          default: begin
            if (count_q < CW'(2)) begin
              res_err_d = ERR_FEW;
            end else begin
              rd_en   = 1'b1;
              state_d = S_RIGHT;
            end
          end
        endcase
      end
      S_READ: begin
        res_value_d = rd_data;
        if (op_q == OP_POP) begin
          count_d = top_idx;
        end
        state_d = S_DONE;
      end
      S_RIGHT: begin
        rhs_d   = rd_data;
        rd_en   = 1'b1;
        rd_addr = AW'(second_idx);
        state_d = S_LEFT;
      end
      S_LEFT: begin
        if (op_q == OP_DIV && rhs_q == '0) begin
          res_err_d = ERR_DIVZERO;
          state_d   = S_DONE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          res_value_d = alu_rsp.result;
          wr_en       = 1'b1;
          wr_addr     = AW'(second_idx);
          wr_data     = alu_rsp.result;
          count_d     = top_idx;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = res_value_q;
          out_err_d   = res_err_q;
          out_count_d = 11'(count_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    data_q      <= data_d;
    pos_q       <= pos_d;
    rhs_q       <= rhs_d;
    res_value_q <= res_value_d;
    res_err_q   <= res_err_d;
    out_value_q <= out_value_d;
    out_err_q   <= out_err_d;
    out_count_q <= out_count_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.value       = out_value_q;
  assign out_o.error_code  = out_err_q;
  assign out_o.entry_count = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("Stack count exceeds the depth.");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_EXEC))
    else $error("Accepted beat did not start execution.");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_EXEC || state_q == S_ALU))
    else $error("Stack write outside the push or write-back step.");

  a_alu_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_ALU))
    else $error("Arithmetic result arrived while not waiting for it.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("Stack count moved by more than one entry.");

endmodule

@@ sim/postfix_stack_calculator_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for postfix_stack_calculator: a directed table and random command
// streams, each result beat compared with a stack predictor. Depends on psc_pkg, psc_in_if,
// psc_out_if and the postfix_stack_calculator RTL.
module postfix_stack_calculator_test;
  import psc_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] value;
    err_e        code;
    logic [10:0] count;
  } stack_result_t;

  typedef struct packed {
    opcode_e       op;
    logic [31:0]   data;
    logic [9:0]    pos;
    logic          known;
    stack_result_t fixed;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  psc_in_if  cmd_if ();
  psc_out_if rsp_if ();

  postfix_stack_calculator #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (rsp_if)
  );

  logic [31:0]   stack_mem [DEPTH];
  int unsigned   depth_used;
  stack_result_t pending_results [$];
  table_row_t    directed_rows [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] floor_quotient(logic [31:0] num, logic [31:0] den);
    logic [31:0] nmag;
    logic [31:0] dmag;
    logic [31:0] quo;
    logic [31:0] rem;
    nmag = num[31] ? (32'd0 - num) : num;
    dmag = den[31] ? (32'd0 - den) : den;
    quo  = nmag / dmag;
    rem  = nmag % dmag;
    if (num[31] != den[31]) begin
      quo = 32'd0 - quo;
      if (rem != 32'd0) quo = quo - 32'd1;
    end
    return quo;
  endfunction

  function automatic stack_result_t compute_stack_result(opcode_e op, logic [31:0] data,
                                                         logic [9:0] pos);
    stack_result_t res;
    logic [31:0]   lhs;
    logic [31:0]   rhs;
    res.value = '0;
    res.code  = ERR_OK;
    case (op)
      OP_PUSH: begin
        if (depth_used >= DEPTH) begin
          res.code = ERR_FULL;
        end else begin
          stack_mem[depth_used] = data;
          depth_used++;
        end
      end
      OP_POP: begin
        if (depth_used == 0) begin
          res.code = ERR_EMPTY;
        end else begin
          depth_used--;
          res.value = stack_mem[depth_used];
        end
      end
      OP_PEEK_TOP: begin
        if (pos >= depth_used) res.code = ERR_RANGE;
        else res.value = stack_mem[depth_used - 1 - pos];
      end
      OP_PEEK_BOTTOM: begin
        if (pos >= depth_used) res.code = ERR_RANGE;
        else res.value = stack_mem[pos];
      end
      default: begin
        if (depth_used < 2) begin
          res.code = ERR_FEW;
        end else begin
          rhs = stack_mem[depth_used - 1];
          lhs = stack_mem[depth_used - 2];
          if (op == OP_DIV && rhs == 32'd0) begin
            res.code = ERR_DIVZERO;
          end else begin
            case (op)
              OP_ADD:  res.value = lhs + rhs;
              OP_SUB:  res.value = lhs - rhs;
              OP_MUL:  res.value = lhs * rhs;
              default: res.value = floor_quotient(lhs, rhs);
            endcase
            depth_used--;
            stack_mem[depth_used - 1] = res.value;
          end
        end
      end
    endcase
    if (res.code != ERR_OK) res.value = '0;
    res.count = 11'(depth_used);
    return res;
  endfunction

  task automatic send_cmd(opcode_e op, logic [31:0] data, logic [9:0] pos,
                          logic known, stack_result_t fixed);
    stack_result_t want;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.opcode     <= op;
    cmd_if.push_value <= data;
    cmd_if.position   <= pos;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    want = compute_stack_result(op, data, pos);
    pending_results.push_back(known ? fixed : want);
  endtask

  task automatic hold_until_drained();
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic table_row(opcode_e op, logic [31:0] data, logic [9:0] pos, logic known,
                           logic [31:0] value, err_e code, logic [10:0] count);
    table_row_t row;
    row.op          = op;
    row.data        = data;
    row.pos         = pos;
    row.known       = known;
    row.fixed.value = value;
    row.fixed.code  = code;
    row.fixed.count = count;
    directed_rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return 32'hffff_ffff;
      4, 5:    return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command(output opcode_e op, output logic [31:0] data,
                                output logic [9:0] pos);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    data = pick_operand();
    pos  = 10'($urandom_range(0, 1023));
    if (pick < 5) begin
      op = opcode_e'($urandom_range(0, 7));
    end else if (depth_used < 2 || pick < 35) begin
      op = OP_PUSH;
    end else if (pick < 45) begin
      op = OP_POP;
    end else if (pick < 65) begin
      op = (pick < 55) ? OP_PEEK_TOP : OP_PEEK_BOTTOM;
      if ($urandom_range(0, 9) < 8) pos = 10'($urandom_range(0, depth_used - 1));
    end else if (pick < 74) begin
      op = OP_ADD;
    end else if (pick < 82) begin
      op = OP_SUB;
    end else if (pick < 90) begin
      op = OP_MUL;
    end else begin
      op = OP_DIV;
    end
  endtask

  task automatic fill_to_full();
    hold_until_drained();
    while (depth_used < DEPTH) send_cmd(OP_PUSH, $urandom, '0, 1'b0, '0);
    send_cmd(OP_PUSH, 32'h1234_5678, '0, 1'b1, '{32'd0, ERR_FULL, 11'd1024});
    send_cmd(OP_PUSH, 32'hffff_ffff, 10'h3ff, 1'b1, '{32'd0, ERR_FULL, 11'd1024});
    send_cmd(OP_PEEK_TOP, '0, 10'h3ff, 1'b0, '0);
    send_cmd(OP_PEEK_BOTTOM, '0, 10'h3ff, 1'b0, '0);
    send_cmd(OP_PEEK_BOTTOM, '0, 10'h000, 1'b0, '0);
    send_cmd(OP_ADD, '0, '0, 1'b0, '0);
    send_cmd(OP_PUSH, 32'h0000_0003, '0, 1'b0, '0);
    send_cmd(OP_PUSH, 32'h0000_0001, '0, 1'b1, '{32'd0, ERR_FULL, 11'd1024});
    send_cmd(OP_DIV, '0, '0, 1'b0, '0);
    send_cmd(OP_POP, '0, '0, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[postfix_stack_calculator] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_check
    stack_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result beat: value %h code %0d count %0d",
                   rsp_if.value, rsp_if.error_code, rsp_if.entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.value !== want.value || rsp_if.error_code !== want.code ||
            rsp_if.entry_count !== want.count) begin
          if (mismatch_count < MAX_REPORTS)
            $display("mismatch: expected value %h code %0d count %0d, got %h %0d %0d",
                     want.value, want.code, want.count,
                     rsp_if.value, rsp_if.error_code, rsp_if.entry_count);
          mismatch_count++;
        end
      end
    end
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin : stimulus
    opcode_e     op;
    logic [31:0] data;
    logic [9:0]  pos;
    int unsigned waited;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.opcode     = OP_PUSH;
    cmd_if.push_value = '0;
    cmd_if.position   = '0;
    depth_used        = 0;
    send_idle_pct     = 31;
    recv_idle_pct     = 69;

    table_row(OP_POP,         '0,           10'd0,   1'b1, 32'd0, ERR_EMPTY, 11'd0);
    table_row(OP_PEEK_TOP,    '0,           10'd0,   1'b1, 32'd0, ERR_RANGE, 11'd0);
    table_row(OP_PEEK_BOTTOM, '0,           10'h3ff, 1'b1, 32'd0, ERR_RANGE, 11'd0);
    table_row(OP_ADD,         '0,           10'd0,   1'b1, 32'd0, ERR_FEW,   11'd0);
    table_row(OP_PUSH,        32'h7fffffff, 10'h3ff, 1'b1, 32'd0, ERR_OK,    11'd1);
    table_row(OP_MUL,         '0,           10'd0,   1'b1, 32'd0, ERR_FEW,   11'd1);
    table_row(OP_DIV,         '0,           10'd0,   1'b1, 32'd0, ERR_FEW,   11'd1);
    table_row(OP_PUSH,        32'h80000000, 10'd0,   1'b1, 32'd0, ERR_OK,    11'd2);
    table_row(OP_PEEK_TOP,    '0,           10'd0,   1'b1, 32'h80000000, ERR_OK, 11'd2);
    table_row(OP_PEEK_BOTTOM, '0,           10'd0,   1'b1, 32'h7fffffff, ERR_OK, 11'd2);
    table_row(OP_PEEK_TOP,    '0,           10'd1,   1'b1, 32'h7fffffff, ERR_OK, 11'd2);
    table_row(OP_PEEK_BOTTOM, '0,           10'd2,   1'b1, 32'd0, ERR_RANGE, 11'd2);
    table_row(OP_ADD,         '0,           10'd0,   1'b1, 32'hffffffff, ERR_OK, 11'd1);
    table_row(OP_PUSH,        32'd0,        10'd0,   1'b1, 32'd0, ERR_OK,    11'd2);
    table_row(OP_DIV,         '0,           10'd0,   1'b1, 32'd0, ERR_DIVZERO, 11'd2);
    table_row(OP_POP,         '0,           10'd0,   1'b1, 32'd0, ERR_OK,    11'd1);
    table_row(OP_POP,         '0,           10'd0,   1'b1, 32'hffffffff, ERR_OK, 11'd0);
    table_row(OP_PUSH,        32'h80000000, 10'd0,   1'b1, 32'd0, ERR_OK,    11'd1);
    table_row(OP_PUSH,        32'hffffffff, 10'd0,   1'b1, 32'd0, ERR_OK,    11'd2);
    table_row(OP_DIV,         '0,           10'd0,   1'b1, 32'h80000000, ERR_OK, 11'd1);
    table_row(OP_PUSH,        32'd7,        10'd0,   1'b0, '0, ERR_OK, '0);
    table_row(OP_SUB,         '0,           10'd0,   1'b0, '0, ERR_OK, '0);
    table_row(OP_PUSH,        32'hfffffffd, 10'd0,   1'b0, '0, ERR_OK, '0);
    table_row(OP_DIV,         '0,           10'd0,   1'b0, '0, ERR_OK, '0);
    table_row(OP_PUSH,        32'd5,        10'd0,   1'b0, '0, ERR_OK, '0);
    table_row(OP_MUL,         '0,           10'd0,   1'b0, '0, ERR_OK, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].op, directed_rows[i].data, directed_rows[i].pos,
               directed_rows[i].known, directed_rows[i].fixed);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 31 : 0;
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 1 && i == 40) hold_until_drained();
        if (phase == 2 && i == 40) fill_to_full();
        random_command(op, data, pos);
        send_cmd(op, data, pos, 1'b0, '0);
      end
    end

    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < DRAIN_WAIT) begin
      @(posedge clk_i);
      waited++;
    end

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[postfix_stack_calculator] OK");
    end else begin
      $display("[postfix_stack_calculator] ERROR");
    end
    $finish;
  end

endmodule

@@ postfix_stack_calculator.f @@
src/psc_pkg.sv
src/psc_in_if.sv
src/psc_out_if.sv
src/psc_ram.sv
src/psc_alu.sv
src/postfix_stack_calculator.sv
sim/postfix_stack_calculator_test.sv
